// ===== sv/ordered_array_list_macros.svh =====
// Assertion macros for the ordered array list.
// Expects signals named clock and reset in the including scope.
`ifndef ORDERED_ARRAY_LIST_MACROS_SVH
`define ORDERED_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OAL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OAL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/oal_pkg.sv =====
// Shared opcodes, status codes, field widths and cell control type
// for the ordered array list. No dependencies.
`default_nettype none

package oal_pkg;

   localparam int OP_W       = 3;
   localparam int POS_W      = 8;
   localparam int VALUE_W    = 32;

   localparam int DEF_LIST_DEPTH    = 64;
   localparam int DEF_ELEMENT_WIDTH = 32;

   localparam logic [OP_W-1:0] OP_GET    = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic sample;
      logic shift_up;
      logic shift_down;
      logic read_sel;
      logic locate;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/oal_cell.sv =====
// One list cell: holds one element, shifts with its neighbors, and
// registers its select and match results. Depends on oal_pkg.
`default_nettype none

module oal_cell
   import oal_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 7,
   parameter int CMP_W = 9,
   parameter int EW    = 32
) (
   input  wire logic              clock,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [CMP_W-1:0]  slot,
   input  wire logic [CNT_W-1:0]  count,
   input  wire logic [EW-1:0]     value,
   input  wire logic [EW-1:0]     left_data,
   input  wire logic [EW-1:0]     right_data,
   output logic      [EW-1:0]     data,
   output logic      [EW-1:0]     pick,
   output logic                   match
);

   logic [EW-1:0] data_ff, data_in;
   logic [EW-1:0] pick_ff, pick_in;
   logic          match_ff, match_in;
   logic          at_slot, above_slot, in_use;

   always_comb begin
      at_slot    = (slot == CMP_W'(IDX));
      above_slot = (CMP_W'(IDX) > slot);
      in_use     = ({1'b0, CMP_W'(IDX)} < {1'b0, CMP_W'(count)});

      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (above_slot) begin
            data_in = left_data;
         end else if (at_slot) begin
            data_in = value;
         end
      end else if (ctrl.shift_down) begin
         if (at_slot || above_slot) begin
            data_in = right_data;
         end
      end

      pick_in  = (ctrl.read_sel && at_slot) ? data_ff : '0;
      match_in = ctrl.locate && in_use && (data_ff == value);
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.sample) begin
         pick_ff  <= pick_in;
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign pick  = pick_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ===== sv/ordered_array_list.sv =====
// Top level of the ordered array list: decode, a chain of oal_cell
// instances, and a registered select and encode stage. Uses oal_pkg.
//
//   port group   dir   contents
//   req_*        in    opcode, position, item_value
//   rsp_*        out   status, read_value, found_position, list_length, list_empty
//
// One transfer per cycle sustained while rsp_stall is low.
// Cells shift in the accept cycle; the select and encode stage then ORs the cell
// picks and priority-encodes the match bits into the output register.
// Reset clears the count; stored elements are not cleared.
// A stalled result holds one item in the cell stage, then req_stall rises.
`default_nettype none

module ordered_array_list
   import oal_pkg::*;
#(
   parameter int LIST_DEPTH    = DEF_LIST_DEPTH,
   parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
   localparam int CNT_W = $clog2(LIST_DEPTH + 1),
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_opcode,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [VALUE_W-1:0] req_item_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_status,
   output logic      [VALUE_W-1:0] rsp_read_value,
   output logic      [CNT_W-1:0]   rsp_found_position,
   output logic      [CNT_W-1:0]   rsp_list_length,
   output logic                    rsp_list_empty
);

   `include "ordered_array_list_macros.svh"

   localparam int EW = ELEMENT_WIDTH;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_status_ff;
   logic [CNT_W-1:0] s1_len_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff;
   logic [EW-1:0]    rsp_read_ff;
   logic [CNT_W-1:0] rsp_found_ff;
   logic [CNT_W-1:0] rsp_len_ff;

   logic             accept, s1_adv;
   logic             status_in;
   logic             rd_ok, ins_ok;
   logic [CMP_W-1:0] pos_w, cnt_w, slot;
   logic [63:0]      value_ext, read_ext;
   logic [EW-1:0]    value;
   cell_ctrl_type    ctrl;

   logic [EW-1:0]    data_w [LIST_DEPTH];
   logic [EW-1:0]    pick_w [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] match_w;
   logic [EW-1:0]    read_or;
   logic [CNT_W-1:0] found;

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pos_w     = CMP_W'(req_position);
      cnt_w     = CMP_W'(count_ff);
      slot      = pos_w - CMP_W'(1);
      value_ext = 64'(req_item_value);
      value     = value_ext[EW-1:0];
      rd_ok     = (pos_w != '0) && (pos_w <= cnt_w);
      ins_ok    = (count_ff < CNT_W'(LIST_DEPTH)) && (pos_w != '0) &&
                  (pos_w <= cnt_w + CMP_W'(1));

      count_in  = count_ff;
      status_in = STATUS_OK;
      ctrl      = '0;
      unique case (req_opcode)
         OP_GET: begin
            status_in     = rd_ok ? STATUS_OK : STATUS_ERR;
            ctrl.read_sel = rd_ok;
         end
         OP_INSERT: begin
            status_in     = ins_ok ? STATUS_OK : STATUS_ERR;
            ctrl.shift_up = ins_ok && accept;
            if (ins_ok) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            status_in       = rd_ok ? STATUS_OK : STATUS_ERR;
            ctrl.read_sel   = rd_ok;
            ctrl.shift_down = rd_ok && accept;
            if (rd_ok) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_LOCATE: begin
            ctrl.locate = 1'b1;
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = STATUS_ERR;
         end
      endcase
      ctrl.sample = accept;
   end

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [EW-1:0] left_d, right_d;
      if (g == 0) begin : g_first
         assign left_d = value;
      end else begin : g_mid_l
         assign left_d = data_w[g-1];
      end
      if (g == LIST_DEPTH - 1) begin : g_last
         assign right_d = data_w[g];
      end else begin : g_mid_r
         assign right_d = data_w[g+1];
      end

      oal_cell #(
         .IDX   (g),
         .CNT_W (CNT_W),
         .CMP_W (CMP_W),
         .EW    (EW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot       (slot),
         .count      (count_ff),
         .value      (value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (data_w[g]),
         .pick       (pick_w[g]),
         .match      (match_w[g])
      );
   end

   always_comb begin
      read_or = '0;
      found   = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         read_or = read_or | pick_w[i];
      end
      for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
         if (match_w[i]) begin
            found = CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status_in;
         s1_len_ff    <= count_in;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_status_ff <= s1_status_ff;
         rsp_read_ff   <= read_or;
         rsp_found_ff  <= found;
         rsp_len_ff    <= s1_len_ff;
      end
   end

   assign read_ext           = 64'(rsp_read_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = read_ext[VALUE_W-1:0];
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_len_ff;
   assign rsp_list_empty     = (rsp_len_ff == '0);

   `OAL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(LIST_DEPTH),
      "element count above list depth")
   `OAL_ASSERT_NEXT(a_insert_grows, accept && ctrl.shift_up,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the count")
   `OAL_ASSERT_NOW(a_found_in_list, rsp_valid_ff,
      rsp_found_ff <= rsp_len_ff, "found position beyond list length")
   `OAL_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_len_ff), "cell stage lost an item while blocked")

endmodule

`default_nettype wire
